/* rtl/cpr_pkg.sv */
// Shared types, constants and helpers for the clock page replacement block.
// Used by cpr_page_mem, cpr_engine and clock_page_replacement; no dependencies.
package cpr_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;
  localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam logic [15:0] FAULT_MAX = 16'hFFFF;

  typedef logic [FRAME_W-1:0]   frame_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [PAGE_BITS-1:0] page_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SWEEP,
    ST_EVICT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        en;
    frame_t      addr;
    page_t       data;
  } mem_wr_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  frame_index;
    logic        evicted_valid;
    logic [15:0] evicted_page;
    logic [15:0] faults_so_far;
  } res_t;

  function automatic cnt_t active_count(input logic [3:0] cfg);
    logic [7:0] c;
    c = {4'b0, cfg};
    if (c == 8'd0) return cnt_t'(1);
    if (c > 8'(FRAMES)) return cnt_t'(FRAMES);
    return c[CNT_W-1:0];
  endfunction

  function automatic frame_t next_frame(input frame_t f, input cnt_t count);
    cnt_t n;
    n = cnt_t'(f) + cnt_t'(1);
    return (n >= count) ? frame_t'(0) : n[FRAME_W-1:0];
  endfunction

  function automatic page_t to_page(input logic [15:0] v);
    logic [47:0] t;
    t = {32'b0, v};
    return t[PAGE_BITS-1:0];
  endfunction

  function automatic logic [15:0] page_to_out(input page_t p);
    logic [47:0] t;
    t = {{(48 - PAGE_BITS){1'b0}}, p};
    return t[15:0];
  endfunction

  function automatic logic [2:0] to_idx3(input frame_t f);
    logic [7:0] t;
    t = {{(8 - FRAME_W){1'b0}}, f};
    return t[2:0];
  endfunction

endpackage

/* rtl/cpr_page_mem.sv */
// Page number store: one entry per frame, one write and one registered read port.
// Depends on cpr_pkg.
module cpr_page_mem (
  input  logic             clk,
  input  cpr_pkg::mem_wr_t wr,
  input  cpr_pkg::frame_t  raddr,
  output cpr_pkg::page_t   rdata
);
  import cpr_pkg::*;

  page_t mem [FRAMES];
  page_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/cpr_engine.sv */
// Replacement sequencer: search, hand sweep and frame fill over the page store,
// with reference and valid bits, clock hand and fault counter. Depends on cpr_pkg.
module cpr_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [15:0]        in_page_number,
  output logic               in_stall,
  input  logic               cfg_wr_en,
  input  logic [3:0]         cfg_wr_data,
  output logic               res_valid,
  output cpr_pkg::res_t      res,
  input  logic               res_ready,
  output cpr_pkg::mem_wr_t   mem_wr,
  output cpr_pkg::frame_t    mem_raddr,
  input  cpr_pkg::page_t     mem_rdata
);
  import cpr_pkg::*;

  state_t            state_r, state_nxt;
  logic [3:0]        cfg_r;
  cnt_t              count_r, count_nxt;
  page_t             page_r, page_nxt;
  frame_t            chk_r, chk_nxt;
  frame_t            hand_r, hand_nxt;
  frame_t            used_r, used_nxt;
  logic              hit_r, hit_nxt;
  logic              ev_valid_r, ev_valid_nxt;
  logic [15:0]       ev_page_r, ev_page_nxt;
  logic [15:0]       fault_r, fault_nxt;
  logic [FRAMES-1:0] ref_r, ref_nxt;
  logic [FRAMES-1:0] valid_r, valid_nxt;
  cnt_t              count_in;

  assign count_in = active_count(cfg_r);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    page_nxt     = page_r;
    chk_nxt      = chk_r;
    hand_nxt     = hand_r;
    used_nxt     = used_r;
    hit_nxt      = hit_r;
    ev_valid_nxt = ev_valid_r;
    ev_page_nxt  = ev_page_r;
    fault_nxt    = fault_r;
    ref_nxt      = ref_r;
    valid_nxt    = valid_r;
    mem_raddr    = frame_t'(0);
    mem_wr       = '0;
    in_stall     = 1'b1;
    res_valid    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          count_nxt = count_in;
          page_nxt  = to_page(in_page_number);
          chk_nxt   = frame_t'(0);
          if (cnt_t'(hand_r) >= count_in) begin
            hand_nxt = frame_t'(0);
          end
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // read data belongs to frame chk_r
        mem_raddr = chk_r + frame_t'(1);
        if (valid_r[chk_r] && mem_rdata == page_r) begin
          hit_nxt         = 1'b1;
          used_nxt        = chk_r;
          ev_valid_nxt    = 1'b0;
          ev_page_nxt     = 16'd0;
          ref_nxt[chk_r]  = 1'b1;
          hand_nxt        = next_frame(chk_r, count_r);
          state_nxt       = ST_OUT;
        end else if (cnt_t'(chk_r) + cnt_t'(1) >= count_r) begin
          hit_nxt   = 1'b0;
          if (fault_r != FAULT_MAX) begin
            fault_nxt = fault_r + 16'd1;
          end
          state_nxt = ST_SWEEP;
        end else begin
          chk_nxt = chk_r + frame_t'(1);
        end
      end
      ST_SWEEP: begin
        mem_raddr = hand_r;
        if (ref_r[hand_r]) begin
          ref_nxt[hand_r] = 1'b0;
          hand_nxt        = next_frame(hand_r, count_r);
        end else begin
          used_nxt  = hand_r;
          state_nxt = ST_EVICT;
        end
      end
      ST_EVICT: begin
        // read of used_r returned; no other access to this entry is in flight
        ev_valid_nxt      = valid_r[used_r];
        ev_page_nxt       = valid_r[used_r] ? page_to_out(mem_rdata) : 16'd0;
        mem_wr.en         = 1'b1;
        mem_wr.addr       = used_r;
        mem_wr.data       = page_r;
        ref_nxt[used_r]   = 1'b1;
        valid_nxt[used_r] = 1'b1;
        hand_nxt          = next_frame(used_r, count_r);
        state_nxt         = ST_OUT;
      end
      ST_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res.hit           = hit_r;
  assign res.frame_index   = to_idx3(used_r);
  assign res.evicted_valid = ev_valid_r;
  assign res.evicted_page  = ev_page_r;
  assign res.faults_so_far = fault_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cfg_r   <= 4'd8;
      hand_r  <= frame_t'(0);
      fault_r <= 16'd0;
      ref_r   <= '0;
      valid_r <= '0;
      count_r <= cnt_t'(1);
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      hand_r  <= hand_nxt;
      fault_r <= fault_nxt;
      ref_r   <= ref_nxt;
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r     <= page_nxt;
    chk_r      <= chk_nxt;
    used_r     <= used_nxt;
    hit_r      <= hit_nxt;
    ev_valid_r <= ev_valid_nxt;
    ev_page_r  <= ev_page_nxt;
  end

  a_search_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEARCH |-> cnt_t'(chk_r) < count_r)
    else $error("search index beyond frames in use");

  a_hand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP || state_r == ST_EVICT || state_r == ST_OUT)
      |-> cnt_t'(hand_r) < count_r)
    else $error("clock hand beyond frames in use");

  a_sweep_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && !ref_r[hand_r])
      |=> (state_r == ST_EVICT && used_r == $past(hand_r)))
    else $error("sweep did not stop at a clear reference bit");

  a_fill_marks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EVICT |=> (state_r == ST_OUT && ref_r[used_r] && valid_r[used_r]))
    else $error("filled frame lacks reference or valid mark");

endmodule

/* rtl/clock_page_replacement.sv */
// Clock (second-chance) page replacement, top level with the output word register.
// Depends on cpr_pkg, cpr_page_mem and cpr_engine.
// Sequence: a hit stops the search at its frame and goes to the output register;
//   a fault searches every frame in use, sweeps past each set reference bit, then fills.
// Throughput: one word at a time; the page store read port scans one frame a cycle.
// Reset: synchronous active-low rst_n empties all frames, hand to frame 0,
//   fault count to zero, frames_in_use to 8; no clearing pass is needed.
module clock_page_replacement (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [15:0] in_page_number,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [2:0]  out_frame_index,
  output logic        out_evicted_valid,
  output logic [15:0] out_evicted_page,
  output logic [15:0] out_faults_so_far,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);
  import cpr_pkg::*;

  mem_wr_t mem_wr;
  frame_t  mem_raddr;
  page_t   mem_rdata;
  logic    res_valid;
  logic    res_ready;
  res_t    res;
  logic    out_valid_r;
  res_t    out_r;

  // Page numbers live in a small synchronous store; the engine reads,
  // compares and writes it back. Writes happen only on a fill, and no read
  // whose data is used lands on the edge of that write, so no forwarding.
  cpr_page_mem u_mem (
    .clk   (clk),
    .wr    (mem_wr),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cpr_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_page_number (in_page_number),
    .in_stall       (in_stall),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .res_valid      (res_valid),
    .res            (res),
    .res_ready      (res_ready),
    .mem_wr         (mem_wr),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  // Take a finished word when the output register is empty or draining.
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  // Hold the payload while stalled; load only on a handoff.
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_r.hit;
  assign out_frame_index   = out_r.frame_index;
  assign out_evicted_valid = out_r.evicted_valid;
  assign out_evicted_page  = out_r.evicted_page;
  assign out_faults_so_far = out_r.faults_so_far;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for clock_page_replacement: directed table, random references
// and frame-count changes, including out-of-range counts.
// Depends on cpr_pkg and the clock_page_replacement RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cpr_pkg::*;

  // Cycles without any accepted word before the run is declared hung; the long
  // receiver hold-off is HOLD_CYCLES.
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 240;
  localparam int PHASE_ITEMS  = 120;
  localparam int REPORT_LIMIT = 40;

  typedef enum logic {ROW_REF, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_t;

  // One row of the directed table: a page reference or a frame-count write.
  // A reference with typed set carries its expected word; otherwise the predictor decides.
  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] value;
    logic        typed;
    res_t        want;
  } dir_row_t;

  localparam res_t UNTYPED = '0;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic [15:0] in_page_number;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_hit;
  logic [2:0]  out_frame_index;
  logic        out_evicted_valid;
  logic [15:0] out_evicted_page;
  logic [15:0] out_faults_so_far;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;

  clock_page_replacement i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_page_number   (in_page_number),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_frame_index  (out_frame_index),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_page (out_evicted_page),
    .out_faults_so_far(out_faults_so_far),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Frame table mirror: the page each frame holds, its reference bit and valid mark,
  // plus the clock hand, the fault count and the frame-count register.
  logic [15:0] frame_pages [FRAMES];
  logic        frame_refs  [FRAMES];
  logic        frame_full  [FRAMES];
  int          hand_pos;
  logic [15:0] fault_total;
  logic [3:0]  frames_reg;

  res_t pending_words [$];
  int   mismatches = 0;

  stall_mode_t stall_mode;
  int          hold_requests;

  // Frame-count register as the hand sees it: zero acts as one, too large acts as all.
  function automatic int frames_active();
    if (frames_reg == 4'd0) return 1;
    if (int'(frames_reg) > FRAMES) return FRAMES;
    return int'(frames_reg);
  endfunction

  // Advance the frame table by one reference and return the word it must produce.
  function automatic res_t resolve_reference(input logic [15:0] pg);
    res_t r;
    int   count;
    int   used;
    int   sweeps;
    logic found;
    r = '0;
    count = frames_active();
    found = 1'b0;
    used = 0;
    // A shrunk frame count can leave the hand past the end: wrap it first.
    if (hand_pos >= count) hand_pos = 0;
    // Lowest-numbered resident frame wins; frames past the count are not searched.
    for (int f = 0; f < count; f++) begin
      if (!found && frame_full[f] && frame_pages[f] == pg) begin
        found = 1'b1;
        used = f;
      end
    end
    if (found) begin
      frame_refs[used] = 1'b1;
    end else begin
      if (fault_total != FAULT_MAX) fault_total++;
      // Give every set bit a second chance; one full lap always clears them all.
      sweeps = 0;
      while (frame_refs[hand_pos] && sweeps < 2 * count + 1) begin
        frame_refs[hand_pos] = 1'b0;
        hand_pos = (hand_pos + 1 >= count) ? 0 : hand_pos + 1;
        sweeps++;
      end
      used = hand_pos;
      if (frame_full[used]) begin
        r.evicted_valid = 1'b1;
        r.evicted_page = frame_pages[used];
      end
      frame_pages[used] = pg;
      frame_refs[used] = 1'b1;
      frame_full[used] = 1'b1;
    end
    hand_pos = (used + 1 >= count) ? 0 : used + 1;
    r.hit = found;
    r.frame_index = 3'(used);
    r.faults_so_far = fault_total;
    return r;
  endfunction

  // Hold the word until it is taken, then log what it must produce.
  // Leave in_valid high: the caller decides whether the next word follows at once.
  task automatic offer_page(input logic [15:0] pg, input logic use_typed, input res_t typed);
    res_t predicted;
    in_valid <= 1'b1;
    in_page_number <= pg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = resolve_reference(pg);
    pending_words.push_back(use_typed ? typed : predicted);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every outstanding word is back, plus a short margin.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_frames(input logic [3:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    frames_reg = v;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly references near a working set so hits and evictions both occur;
  // now and then any page at all, or one of the extremes.
  function automatic logic [15:0] pick_page(input logic [15:0] base);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return 16'($urandom);
    if (roll < 15) return (roll == 12) ? 16'hFFFF : 16'h0000;
    return base + 16'($urandom_range(0, frames_active() + 2));
  endfunction

  // Directed table: first references after reset are typed in (page 0 must not hit an
  // empty frame), then fill-up, a full second-chance lap, a shrink with the hand past
  // the count, a page stranded beyond the count, duplicates, and out-of-range counts.
  dir_row_t directed_rows [] = '{
    '{ROW_REF, 16'h0000, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 16'd1}},
    '{ROW_REF, 16'h0000, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 16'd1}},
    '{ROW_REF, 16'hFFFF, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000, 16'd2}},
    '{ROW_REF, 16'hFFFF, 1'b1, '{1'b1, 3'd1, 1'b0, 16'h0000, 16'd2}},
    '{ROW_REF, 16'h0001, 1'b0, UNTYPED},
    '{ROW_REF, 16'h0002, 1'b0, UNTYPED},
    '{ROW_REF, 16'h0003, 1'b0, UNTYPED},
    '{ROW_REF, 16'h0004, 1'b0, UNTYPED},
    '{ROW_REF, 16'h0005, 1'b0, UNTYPED},
    '{ROW_REF, 16'h0006, 1'b0, UNTYPED},
    '{ROW_REF, 16'h0007, 1'b0, UNTYPED},
    '{ROW_REF, 16'h0005, 1'b0, UNTYPED},
    '{ROW_CFG, 16'h0002, 1'b0, UNTYPED},
    '{ROW_REF, 16'h1234, 1'b0, UNTYPED},
    '{ROW_REF, 16'h0004, 1'b0, UNTYPED},
    '{ROW_CFG, 16'h0008, 1'b0, UNTYPED},
    '{ROW_REF, 16'h0004, 1'b0, UNTYPED},
    '{ROW_REF, 16'h8000, 1'b0, UNTYPED},
    '{ROW_CFG, 16'h0000, 1'b0, UNTYPED},
    '{ROW_REF, 16'hA5A5, 1'b0, UNTYPED},
    '{ROW_REF, 16'h5A5A, 1'b0, UNTYPED},
    '{ROW_REF, 16'hA5A5, 1'b0, UNTYPED},
    '{ROW_CFG, 16'h000F, 1'b0, UNTYPED},
    '{ROW_REF, 16'h5A5A, 1'b0, UNTYPED},
    '{ROW_REF, 16'h0001, 1'b0, UNTYPED},
    '{ROW_REF, 16'h7FFF, 1'b0, UNTYPED}
  };

  // Frame counts for the random phases: extremes, out-of-range values and the middle.
  localparam logic [3:0] PHASE_FRAMES [12] = '{4'd5, 4'd1, 4'd8, 4'd3, 4'd0, 4'd15,
                                               4'd2, 4'd7, 4'd4, 4'd6, 4'd12, 4'd8};

  initial begin
    logic [15:0] base;
    int          burst_left;
    int          gap_max;
    in_valid <= 1'b0;
    in_page_number <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    rst_n <= 1'b0;
    stall_mode = STALL_NONE;
    hold_requests = 0;
    for (int f = 0; f < FRAMES; f++) begin
      frame_pages[f] = '0;
      frame_refs[f] = 1'b0;
      frame_full[f] = 1'b0;
    end
    hand_pos = 0;
    fault_total = '0;
    frames_reg = 4'd8;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: back-to-back, receiver always ready.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_drained();
        write_frames(directed_rows[i].value[3:0]);
      end else begin
        offer_page(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
      end
    end
    wait_drained();

    // Random phases, each under its own frame count and idling style.
    foreach (PHASE_FRAMES[p]) begin
      write_frames(PHASE_FRAMES[p]);
      stall_mode = stall_mode_t'(p % 3);
      gap_max = (p % 4 == 3) ? 0 : 1 + p % 6;
      burst_left = 0;
      base = 16'($urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 30 == 29) base = 16'($urandom);
        // Hold off the receiver once while words keep coming, so the block backs up.
        if (p == 0 && n == 40) hold_requests++;
        // Once, stop sending until every word is back.
        if (p == 1 && n == 60) wait_drained();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          idle_sender($urandom_range(0, gap_max));
        end
        burst_left--;
        offer_page(pick_page(base), 1'b0, UNTYPED);
      end
      wait_drained();
    end

    repeat (30) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Receiver: a stall pattern set per phase, overridden by the long hold-off.
  int   holds_granted = 0;
  int   hold_left = 0;
  int   run_left = 0;
  logic run_stalled = 1'b0;

  always @(posedge clk) begin
    if (hold_left == 0 && holds_granted != hold_requests) begin
      holds_granted++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_RANDOM: begin
          out_stall <= ($urandom_range(0, 2) == 0);
        end
        STALL_RUNS: begin
          if (run_left == 0) begin
            run_stalled = 1'($urandom_range(0, 1));
            run_left = $urandom_range(1, 12);
          end
          run_left--;
          out_stall <= run_stalled;
        end
        default: begin
          out_stall <= 1'b0;
        end
      endcase
    end
  end

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  // Check each word the block hands over against the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $error("result word with no reference outstanding");
      end else begin
        want = pending_words.pop_front();
        compare_field("hit", 16'(want.hit), 16'(out_hit));
        compare_field("frame_index", 16'(want.frame_index), 16'(out_frame_index));
        compare_field("evicted_valid", 16'(want.evicted_valid), 16'(out_evicted_valid));
        compare_field("evicted_page", want.evicted_page, out_evicted_page);
        compare_field("faults_so_far", want.faults_so_far, out_faults_so_far);
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
